[rtl/rlh_pkg.sv]
// rlh_pkg: shared types and constants of the RGB/luma histogram block.
// Used by the controller, datapath and top level; no dependencies.
package rlh_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 17;
	localparam int PEAK_W   = 32;

	// item kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// register indexes
	localparam logic CFG_SAMPLE_DEPTH = 1'b0;
	localparam logic CFG_COLOR_LAYOUT = 1'b1;

	// BT.601 luma weights, Q0.16
	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // latch the input word
		logic prep;      // form bin addresses and range flags
		logic mem_rd;    // read all four bin memories
		logic mem_inc;   // write back incremented counts, update peak
		logic clr;       // zero one row of every memory
		logic div_start; // start the level divider
		logic out_load;  // load the result registers
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic div_done;
	} sts_t;

endpackage

[rtl/rlh_div.sv]
// rlh_div: four-lane restoring divider, count / peak as a fixed-point fraction.
// One quotient bit per cycle per lane.
module rlh_div #(
	parameter int COUNT_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COUNT_BITS-1:0]   count [4],
	input  logic [COUNT_BITS-1:0]   peak,
	output logic                    done,
	output logic [FRACTION_BITS:0]  quot [4]
);

	localparam int QW  = FRACTION_BITS + 1;
	localparam int KW  = $clog2(QW + 1);

	logic [KW-1:0]       step_q;
	logic                busy_q;
	logic [COUNT_BITS:0] rem_q [4];
	logic [QW-1:0]       q_q [4];

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == KW'(QW - 1))
				busy_q <= 1'b0;
			step_q <= step_q + 1'b1;
		end
	end

	assign done = busy_q && (step_q == KW'(QW - 1));

	// lanes: first step compares without shifting
	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [COUNT_BITS:0] cand;
		logic                ge;
		always_comb begin
			cand = (step_q == '0) ? rem_q[l] : {rem_q[l][COUNT_BITS-1:0], 1'b0};
			ge   = cand >= {1'b0, peak};
		end
		always_ff @(posedge clk) begin
			if (start) begin
				rem_q[l] <= {1'b0, (count[l] > peak) ? peak : count[l]};
				q_q[l]   <= '0;
			end else if (busy_q) begin
				rem_q[l] <= ge ? cand - {1'b0, peak} : cand;
				q_q[l]   <= {q_q[l][QW-2:0], ge};
			end
		end
		// last bit comes straight from the compare; afterwards the register holds it
		assign quot[l] = (peak == '0) ? '0 :
			busy_q ? {q_q[l][QW-2:0], ge} : q_q[l];
	end

endmodule

[rtl/rlh_datapath.sv]
// rlh_datapath: bin memories, luma, range checks, peak tracking, result registers.
// Driven by rlh_ctrl commands; instantiates rlh_div. Depends on rlh_pkg.
module rlh_datapath #(
	parameter int BIN_INDEX_BITS = 16,
	parameter int COUNT_BITS     = 32,
	parameter int FRACTION_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlh_pkg::cmd_t                   cmd,
	output rlh_pkg::sts_t                   sts,
	input  logic                            sample_depth_q,
	input  logic                            color_layout_q,
	input  logic [1:0]                      kind,
	input  logic [rlh_pkg::SAMPLE_W-1:0]    red_sample,
	input  logic [rlh_pkg::SAMPLE_W-1:0]    green_sample,
	input  logic [rlh_pkg::SAMPLE_W-1:0]    blue_sample,
	input  logic [rlh_pkg::SAMPLE_W-1:0]    bin_index,
	output logic [rlh_pkg::LEVEL_W-1:0]     red_level,
	output logic [rlh_pkg::LEVEL_W-1:0]     green_level,
	output logic [rlh_pkg::LEVEL_W-1:0]     blue_level,
	output logic [rlh_pkg::LEVEL_W-1:0]     luma_level,
	output logic [rlh_pkg::PEAK_W-1:0]      peak_value
);

	localparam int NUM_BINS = 1 << BIN_INDEX_BITS;
	localparam int SW       = rlh_pkg::SAMPLE_W;
	localparam int QW       = FRACTION_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [1:0]                kind_q;
	logic [SW-1:0]             r_q, g_q, b_q, idx_q;
	logic [SW-1:0]             addr_q [4];
	logic [3:0]                ok_q;
	logic [BIN_INDEX_BITS-1:0] clr_addr_q;
	logic [COUNT_BITS-1:0]     rd_q [4];
	logic [COUNT_BITS-1:0]     peak_q;
	logic [COUNT_BITS-1:0]     inc [4];
	logic [COUNT_BITS-1:0]     div_cnt [4];
	logic [FRACTION_BITS:0]    quot [4];
	logic [31:0]               luma_sum;
	logic [SW-1:0]             luma;
	logic [SW:0]               lim;
	logic [COUNT_BITS-1:0]     peak_nx;
	logic                      div_done;

	// input capture; grayscale copies red into green and blue
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			r_q    <= red_sample;
			g_q    <= color_layout_q ? green_sample : red_sample;
			b_q    <= color_layout_q ? blue_sample : red_sample;
			idx_q  <= bin_index;
		end
	end

	// luma and active range; the weighted sum stays below 2^32
	always_comb begin
		luma_sum = 32'(r_q) * 32'(rlh_pkg::W_RED) + 32'(g_q) * 32'(rlh_pkg::W_GREEN)
			+ 32'(b_q) * 32'(rlh_pkg::W_BLUE);
		luma = luma_sum[31:16];
		lim  = sample_depth_q ? ((SW+1)'(1) << BIN_INDEX_BITS) : (SW+1)'(256);
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			if (kind_q == rlh_pkg::KIND_PIXEL) begin
				addr_q[0] <= r_q;
				addr_q[1] <= g_q;
				addr_q[2] <= b_q;
				addr_q[3] <= luma;
				ok_q      <= {{1'b0, luma} < lim, {1'b0, b_q} < lim,
					{1'b0, g_q} < lim, {1'b0, r_q} < lim};
			end else begin
				for (int c = 0; c < 4; c++)
					addr_q[c] <= idx_q;
				ok_q <= {4{{1'b0, idx_q} < lim}};
			end
		end
	end

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr)
			clr_addr_q <= clr_addr_q + 1'b1;
	end

	assign sts = '{clr_last: &clr_addr_q, div_done: div_done};

	// bin memories, one per channel
	for (genvar c = 0; c < 4; c++) begin : g_ch
		logic [COUNT_BITS-1:0] mem [NUM_BINS];
		assign inc[c] = (rd_q[c] == COUNT_MAX) ? rd_q[c] : rd_q[c] + 1'b1;
		always_ff @(posedge clk) begin
			if (cmd.clr)
				mem[clr_addr_q] <= '0;
			else if (cmd.mem_inc && ok_q[c])
				mem[addr_q[c][BIN_INDEX_BITS-1:0]] <= inc[c];
		end
		always_ff @(posedge clk) begin
			if (cmd.mem_rd)
				rd_q[c] <= mem[addr_q[c][BIN_INDEX_BITS-1:0]];
		end
		assign div_cnt[c] = ok_q[c] ? rd_q[c] : '0;
	end

	// peak over the updated bins
	always_comb begin
		peak_nx = peak_q;
		for (int c = 0; c < 4; c++)
			if (ok_q[c] && inc[c] > peak_nx)
				peak_nx = inc[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			peak_q <= '0;
		else if (cmd.clr)
			peak_q <= '0;
		else if (cmd.mem_inc)
			peak_q <= peak_nx;
	end

	rlh_div #(
		.COUNT_BITS    (COUNT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.count  (div_cnt),
		.peak   (peak_q),
		.done   (div_done),
		.quot   (quot)
	);

	// result registers, widths fitted to the ports
	logic [QW+rlh_pkg::LEVEL_W-1:0]        q_ext [4];
	logic [COUNT_BITS+rlh_pkg::PEAK_W-1:0] p_ext;
	always_comb begin
		for (int c = 0; c < 4; c++)
			q_ext[c] = {{rlh_pkg::LEVEL_W{1'b0}}, quot[c]};
		p_ext = {{rlh_pkg::PEAK_W{1'b0}}, peak_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_level   <= q_ext[0][rlh_pkg::LEVEL_W-1:0];
			green_level <= q_ext[1][rlh_pkg::LEVEL_W-1:0];
			blue_level  <= q_ext[2][rlh_pkg::LEVEL_W-1:0];
			luma_level  <= q_ext[3][rlh_pkg::LEVEL_W-1:0];
			peak_value  <= p_ext[rlh_pkg::PEAK_W-1:0];
		end
	end

endmodule

[rtl/rlh_ctrl.sv]
// rlh_ctrl: sequencer for pixel, read and clear words, and the output valid.
// Issues rlh_pkg::cmd_t to rlh_datapath. Depends on rlh_pkg.
module rlh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    kind,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output rlh_pkg::cmd_t cmd,
	input  rlh_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_INC  = 3'd3;
	localparam logic [2:0] S_DIV0 = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_PUT  = 3'd6;
	localparam logic [2:0] S_CLR  = 3'd7;

	logic [2:0] state_q, state_nx;
	logic       is_pix_q;
	logic       out_valid_q;
	logic       take;
	logic       out_free;

	assign in_stall  = state_q != S_IDLE;
	assign take      = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (kind) inside
						rlh_pkg::KIND_PIXEL, rlh_pkg::KIND_READ: begin
							cmd.load = 1'b1;
							state_nx = S_PREP;
						end
						rlh_pkg::KIND_CLEAR: state_nx = S_CLR;
						default: state_nx = S_IDLE;
					endcase
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_nx = S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_nx   = is_pix_q ? S_INC : S_DIV0;
			end
			S_INC: begin
				cmd.mem_inc = 1'b1;
				state_nx    = S_IDLE;
			end
			S_DIV0: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_nx     = S_IDLE;
					end else begin
						state_nx = S_PUT;
					end
				end
			end
			S_PUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last)
					state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// S_PUT waits for the output register; the divider holds its quotient once
	// done, and no new start is issued before the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			is_pix_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load)
				is_pix_q <= kind == rlh_pkg::KIND_PIXEL;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over an unaccepted word");
	a_inc_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_inc |-> $past(cmd.mem_rd))
		else $error("bin write without preceding read");
	a_div_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_DIV)
		else $error("divider started outside the divide sequence");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !cmd.load)
		else $error("word loaded during clear sweep");

endmodule

[rtl/rgb_luma_histogram.sv]
// rgb_luma_histogram: top level; configuration registers, controller and datapath.
// Depends on rlh_pkg, rlh_ctrl, rlh_datapath, rlh_div.
//
// Input words (in_valid/in_stall) are pixels, bin reads or frame clears,
// selected by kind. Only a read gives an output word (out_valid/out_stall):
// the four bin counts of bin_index divided by the peak, and the peak.
// A pixel runs through capture, address, memory read and write back, set by
// the read-modify-write of the bin memories through one port each.
// A read runs capture, address and memory read, then the divider, which makes
// one quotient bit per cycle for all four channels together.
// A clear sweeps all 2^BIN_INDEX_BITS rows, one per cycle.
// After reset the same sweep runs with in_stall high; configuration writes
// are taken at any time but belong in idle gaps.
// The output register holds a result while out_stall is high; pixel and clear
// words are still accepted then, a following read waits before loading it.
module rgb_luma_histogram #(
	parameter int BIN_INDEX_BITS = 16,
	parameter int COUNT_BITS     = 32,
	parameter int FRACTION_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic                         cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   kind,
	input  logic [rlh_pkg::SAMPLE_W-1:0] red_sample,
	input  logic [rlh_pkg::SAMPLE_W-1:0] green_sample,
	input  logic [rlh_pkg::SAMPLE_W-1:0] blue_sample,
	input  logic [rlh_pkg::SAMPLE_W-1:0] bin_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rlh_pkg::LEVEL_W-1:0]  red_level,
	output logic [rlh_pkg::LEVEL_W-1:0]  green_level,
	output logic [rlh_pkg::LEVEL_W-1:0]  blue_level,
	output logic [rlh_pkg::LEVEL_W-1:0]  luma_level,
	output logic [rlh_pkg::PEAK_W-1:0]   peak_value
);

	logic          sample_depth_q;
	logic          color_layout_q;
	rlh_pkg::cmd_t cmd;
	rlh_pkg::sts_t sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_depth_q <= 1'b0;
			color_layout_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlh_pkg::CFG_SAMPLE_DEPTH: sample_depth_q <= cfg_data;
				rlh_pkg::CFG_COLOR_LAYOUT: color_layout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rlh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rlh_datapath #(
		.BIN_INDEX_BITS (BIN_INDEX_BITS),
		.COUNT_BITS     (COUNT_BITS),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample_depth_q (sample_depth_q),
		.color_layout_q (color_layout_q),
		.kind           (kind),
		.red_sample     (red_sample),
		.green_sample   (green_sample),
		.blue_sample    (blue_sample),
		.bin_index      (bin_index),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level),
		.luma_level     (luma_level),
		.peak_value     (peak_value)
	);

endmodule

[dv/rgb_luma_histogram_test.sv]
// rgb_luma_histogram_test: self-checking testbench for the RGB/luma histogram block.
// Depends on rlh_pkg and rgb_luma_histogram; it keeps its own copy of the bins
// and checks every read word field by field.
`timescale 1ns / 1ps

module rgb_luma_histogram_test;

	localparam int BINS_MAX   = 65536;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [rlh_pkg::LEVEL_W-1:0] red;
		logic [rlh_pkg::LEVEL_W-1:0] green;
		logic [rlh_pkg::LEVEL_W-1:0] blue;
		logic [rlh_pkg::LEVEL_W-1:0] luma;
		logic [rlh_pkg::PEAK_W-1:0]  peak;
	} level_word_t;

	// histogram predictor and store of expected read words
	class histo_scoreboard;
		bit [31:0] counts[4][BINS_MAX];
		bit [31:0] peak;
		bit depth16;
		bit rgb_mode;
		level_word_t expected_q[$];
		int errors;
		int reads_checked;
		int pixels_seen;
		int last_luma;

		function new();
			depth16 = 1'b0;
			rgb_mode = 1'b1;
			peak = '0;
		endfunction

		function int unsigned active_bins();
			return depth16 ? 65536 : 256;
		endfunction

		function void clear_all();
			for (int ch = 0; ch < 4; ch++)
				for (int i = 0; i < BINS_MAX; i++)
					counts[ch][i] = '0;
			peak = '0;
		endfunction

		function void bump(int ch, int unsigned idx);
			if (idx >= active_bins())
				return;
			if (counts[ch][idx] != 32'hFFFF_FFFF)
				counts[ch][idx]++;
			if (counts[ch][idx] > peak)
				peak = counts[ch][idx];
		endfunction

		// count / peak as Q1.16, truncated
		function logic [rlh_pkg::LEVEL_W-1:0] fraction(bit [31:0] c);
			longint unsigned q;
			if (peak == 0)
				return '0;
			if (c > peak)
				c = peak;
			q = (longint'(c) << 16) / longint'(peak);
			return q[rlh_pkg::LEVEL_W-1:0];
		endfunction

		function void note_input(logic [1:0] k, logic [15:0] r, logic [15:0] g,
				logic [15:0] b, logic [15:0] idx);
			longint unsigned y;
			level_word_t w;
			bit [31:0] c[4];
			case (k)
				rlh_pkg::KIND_PIXEL: begin
					if (!rgb_mode) begin
						g = r;
						b = r;
					end
					y = (longint'(rlh_pkg::W_RED) * r + longint'(rlh_pkg::W_GREEN) * g
						+ longint'(rlh_pkg::W_BLUE) * b) >> 16;
					last_luma = int'(y);
					bump(0, r);
					bump(1, g);
					bump(2, b);
					bump(3, 32'(y));
					pixels_seen++;
				end
				rlh_pkg::KIND_CLEAR: clear_all();
				rlh_pkg::KIND_READ: begin
					for (int ch = 0; ch < 4; ch++)
						c[ch] = (idx < active_bins()) ? counts[ch][idx] : '0;
					w.red = fraction(c[0]);
					w.green = fraction(c[1]);
					w.blue = fraction(c[2]);
					w.luma = fraction(c[3]);
					w.peak = peak;
					expected_q.push_back(w);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(level_word_t got);
			level_word_t want;
			if (expected_q.size() == 0) begin
				report("read word with nothing expected");
				return;
			end
			want = expected_q.pop_front();
			reads_checked++;
			if (got.red !== want.red)
				report($sformatf("red_level %0d, want %0d", got.red, want.red));
			if (got.green !== want.green)
				report($sformatf("green_level %0d, want %0d", got.green, want.green));
			if (got.blue !== want.blue)
				report($sformatf("blue_level %0d, want %0d", got.blue, want.blue));
			if (got.luma !== want.luma)
				report($sformatf("luma_level %0d, want %0d", got.luma, want.luma));
			if (got.peak !== want.peak)
				report($sformatf("peak_value %0d, want %0d", got.peak, want.peak));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] kind;
	logic [rlh_pkg::SAMPLE_W-1:0] red_sample, green_sample, blue_sample, bin_index;
	logic out_valid;
	logic out_stall;
	logic [rlh_pkg::LEVEL_W-1:0] red_level, green_level, blue_level, luma_level;
	logic [rlh_pkg::PEAK_W-1:0] peak_value;

	histo_scoreboard sb;
	int cycles;
	int burst_left;
	logic [15:0] pool[16];

	rgb_luma_histogram uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.red_sample(red_sample), .green_sample(green_sample),
		.blue_sample(blue_sample), .bin_index(bin_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_level(red_level), .green_level(green_level),
		.blue_level(blue_level), .luma_level(luma_level),
		.peak_value(peak_value)
	);

	always #4 clk = ~clk;

	// cycle count and timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rgb_luma_histogram_test: done, errors");
			$finish;
		end
	end

	// receiver: check accepted words, stall in changing patterns
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({red_level, green_level, blue_level, luma_level, peak_value});
		case (cycles[10:9])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 1) == 0);
			2'd2: out_stall <= ($urandom_range(0, 9) != 0);
			default: out_stall <= (cycles[2:0] < 3'd5);
		endcase
	end

	// one word through the input channel, then maybe a gap
	task send_word(logic [1:0] k, logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [15:0] idx);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		red_sample <= r;
		green_sample <= g;
		blue_sample <= b;
		bin_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(k, r, g, b, idx);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(0, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drain all expected words; the phase ends with a read so nothing is in flight
	task wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_cfg(logic idx, logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rlh_pkg::CFG_SAMPLE_DEPTH)
			sb.depth16 = val;
		else
			sb.rgb_mode = val;
	endtask

	function logic [15:0] pick_sample();
		if ($urandom_range(0, 9) < 6)
			return pool[$urandom_range(0, 15)];
		if (!sb.depth16 && $urandom_range(0, 4) != 0)
			return 16'($urandom_range(0, 255));
		return 16'($urandom_range(0, 65535));
	endfunction

	function logic [15:0] pick_index();
		case ($urandom_range(0, 3))
			0: return 16'(sb.last_luma);
			1: return pick_sample();
			default: return pool[$urandom_range(0, 15)];
		endcase
	endfunction

	initial begin
		int n;
		bit [1:0] depth_seq[6];
		bit [1:0] mode_seq[6];
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rlh_pkg::CFG_SAMPLE_DEPTH;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		kind = rlh_pkg::KIND_PIXEL;
		red_sample = '0;
		green_sample = '0;
		blue_sample = '0;
		bin_index = '0;
		out_stall = 1'b0;
		cycles = 0;
		burst_left = 0;
		depth_seq = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1};
		mode_seq = '{2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty histogram, extremes, out of range, unused kind, clear
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(rlh_pkg::KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(rlh_pkg::KIND_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(rlh_pkg::KIND_PIXEL, 16'd255, 16'd255, 16'd255, 16'd0);
		send_word(rlh_pkg::KIND_PIXEL, 16'd255, 16'd255, 16'd255, 16'd0);
		send_word(rlh_pkg::KIND_PIXEL, 16'd256, 16'hFFFF, 16'd128, 16'd0);
		send_word(rlh_pkg::KIND_PIXEL, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFFFF);
		send_word(rlh_pkg::KIND_PIXEL, 16'h5555, 16'hAAAA, 16'hFF00, 16'hAAAA);
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd255);
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd128);
		send_word(rlh_pkg::KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256);
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_word(rlh_pkg::KIND_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd255);
		send_word(rlh_pkg::KIND_PIXEL, 16'd77, 16'd200, 16'd3, 16'd0);
		send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd77);
		wait_idle();

		// random phases over depth and layout; two of the depth changes keep the frame
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(rlh_pkg::CFG_SAMPLE_DEPTH, depth_seq[ph][0]);
			write_cfg(rlh_pkg::CFG_COLOR_LAYOUT, mode_seq[ph][0]);
			@(posedge clk);
			for (int i = 0; i < 16; i++)
				pool[i] = depth_seq[ph][0] ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(0, 255));
			pool[0] = depth_seq[ph][0] ? 16'hFFFF : 16'd255;
			if (ph != 2 && ph != 4)
				send_word(rlh_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			for (int i = 0; i < 300; i++) begin
				n = $urandom_range(0, 99);
				if (n < 72)
					send_word(rlh_pkg::KIND_PIXEL, pick_sample(), pick_sample(),
						pick_sample(), 16'($urandom));
				else if (n < 97)
					send_word(rlh_pkg::KIND_READ, 16'($urandom), 16'($urandom),
						16'($urandom), pick_index());
				else
					send_word(rlh_pkg::KIND_UNUSED, 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
			end
			send_word(rlh_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, pool[1]);
			wait_idle();
		end

		repeat (40) @(posedge clk);
		$display("covered %0d pixels and %0d checked reads over six depth/layout phases",
			sb.pixels_seen, sb.reads_checked);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("rgb_luma_histogram_test: done, clean");
		else
			$display("rgb_luma_histogram_test: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/rlh_pkg.sv
rtl/rlh_div.sv
rtl/rlh_datapath.sv
rtl/rlh_ctrl.sv
rtl/rgb_luma_histogram.sv
dv/rgb_luma_histogram_test.sv
